/* hw/rtl/chd_pkg.sv */
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, field layout and codes of the canonical huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

    // table and store geometry
    localparam int MAX_LEN     = 16;
    localparam int SYMBOLS     = 256;
    localparam int SYMBOL_BITS = 16;

    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = $clog2(SYMBOLS);
    localparam int CODE_W   = 16;
    localparam int INDEX_W  = 9;
    localparam int COUNT_W  = 9;
    localparam int SLOT_W   = 8;
    localparam int WINDOW_W = 16;
    localparam int CMD_W    = 2;

    // signed index: fits first index + code - first code with a sign bit
    localparam int IDX_W = CODE_W + 2;

    // input tdata layout, lowest field first
    localparam int LSLOT_LSB  = 0;
    localparam int LSLOT_W    = 5;
    localparam int FCODE_LSB  = LSLOT_LSB + LSLOT_W;
    localparam int FINDEX_LSB = FCODE_LSB + CODE_W;
    localparam int SSLOT_LSB  = FINDEX_LSB + INDEX_W;
    localparam int SVALUE_LSB = SSLOT_LSB + SLOT_W;
    localparam int SVALUE_W   = 16;
    localparam int WINDOW_LSB = SVALUE_LSB + SVALUE_W;
    localparam int S_DATA_RAW = WINDOW_LSB + WINDOW_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_LEN_W  = 5;
    localparam int OUT_SYM_W  = 16;
    localparam int M_DATA_RAW = OUT_LEN_W + OUT_SYM_W;
    localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD_LENGTH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SYMBOL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE      = 2'd2;

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT    = 1'd1;

    localparam logic [LSLOT_W-1:0] MCL_RESET   = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    typedef logic [CODE_W-1:0]      code_t;
    typedef logic [INDEX_W-1:0]     index_t;
    typedef logic [SYMBOL_BITS-1:0] symbol_t;

    typedef struct packed {
        logic [LEN_W-1:0]  found_len;
        logic              bad;
        logic [ADDR_W-1:0] addr;
    } search_result_t;

endpackage

/* hw/rtl/chd_length_search.sv */
// ----------------------------------------------------------------------------
// chd_length_search
// Finds the code length at the window start and the symbol store index.
// ----------------------------------------------------------------------------
module chd_length_search
    import chd_pkg::*;
(
    input  logic [WINDOW_W-1:0] bit_window,
    input  logic [LSLOT_W-1:0]  max_code_length,
    input  logic [COUNT_W-1:0]  symbol_count,
    input  code_t               fc_table [MAX_LEN+1],
    input  index_t              fi_table [MAX_LEN+1],
    output search_result_t      result
);

    logic [LEN_W-1:0]    width;
    logic [WINDOW_W:0]   mask;
    logic [WINDOW_W-1:0] window;
    logic [MAX_LEN:1]    match;
    logic [LEN_W-1:0]    len;
    logic [WINDOW_W-1:0] code;
    logic [IDX_W-1:0]    idx;
    logic                bad;

    always_comb begin
        if (max_code_length > LSLOT_W'(MAX_LEN)) begin
            width = LEN_W'(MAX_LEN);
        end else begin
            width = LEN_W'(max_code_length);
        end
        mask   = ((WINDOW_W+1)'(1) << width) - (WINDOW_W+1)'(1);
        window = bit_window & mask[WINDOW_W-1:0];
    end

    // fc << s <= w is the same test as fc <= (w >> s)
    always_comb begin
        for (int m = 1; m <= MAX_LEN; m++) begin
            match[m] = (LEN_W'(m) <= width) &&
                       (fc_table[m] <= CODE_W'(window >> (width - LEN_W'(m))));
        end
    end

    always_comb begin
        len = '0;
        for (int m = 1; m <= MAX_LEN; m++) begin
            if (match[m]) begin
                len = LEN_W'(m);
            end
        end
    end

    always_comb begin
        if (len == '0) begin
            code = '0;
        end else begin
            code = window >> (width - len);
        end
        idx = IDX_W'(fi_table[len]) + IDX_W'(code) - IDX_W'(fc_table[len]);
        // a negative index wraps to a huge value and is out of range
        bad = idx[IDX_W-1] ||
              (idx[IDX_W-2:0] >= (IDX_W-1)'(symbol_count)) ||
              (idx[IDX_W-2:0] >= (IDX_W-1)'(SYMBOLS));
        result.found_len = len;
        result.bad       = bad;
        result.addr      = idx[ADDR_W-1:0];
    end

endmodule

/* hw/rtl/chd_symbol_store.sv */
// ----------------------------------------------------------------------------
// chd_symbol_store
// Symbol memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module chd_symbol_store
    import chd_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  symbol_t           wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output symbol_t           rd_data
);

    symbol_t mem [SYMBOLS];
    symbol_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while the result waits downstream
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/canonical_huffman_decoder.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_decoder
// Canonical huffman decoder with loadable length table and symbol store.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_      | in        | tuser: command; tdata: length_slot, first_code_value,
//          |           |   first_index_value, symbol_slot, symbol_value,
//          |           |   bit_window
//  m_      | out       | tdata: code_length, symbol; tuser: bad_code
//  cfg_    | in        | cfg_index, cfg_data (0 max_code_length, 1 symbol_count)
//
//  one item per cycle unless the result channel stalls; a decode result passes
//  through the input register and then the symbol memory's registered read
//  loads are written to the tables from the input register and give no result
//  reset clears valid flags and config; tables are undefined until loaded
//  a stalled result stalls decodes only as far as empty stages allow
// ----------------------------------------------------------------------------
module canonical_huffman_decoder
    import chd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // length_slot, first_code_value,
                                             // first_index_value, symbol_slot,
                                             // symbol_value, bit_window
    input  logic [CMD_W-1:0]      s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // code_length, symbol
    output logic                  m_tuser,   // bad_code
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                 v1_reg, v1_next;
    logic [CMD_W-1:0]     cmd1_reg;
    logic [S_DATA_W-1:0]  data1_reg;
    logic                 v2_reg, v2_next;
    logic [LEN_W-1:0]     len2_reg;
    logic                 bad2_reg;
    logic [LSLOT_W-1:0]   mcl_reg;
    logic [COUNT_W-1:0]   count_reg;
    code_t                fc_table_reg [MAX_LEN+1];
    index_t               fi_table_reg [MAX_LEN+1];

    logic                 is_decode;
    logic                 en2;
    logic                 fire1;
    logic                 dec_fire;
    logic                 s_accept;
    logic [LSLOT_W-1:0]   length_slot;
    logic [SLOT_W-1:0]    symbol_slot;
    logic                 len_wr;
    logic                 sym_wr;
    search_result_t       search;
    symbol_t              rd_symbol;

    assign length_slot = data1_reg[LSLOT_LSB +: LSLOT_W];
    assign symbol_slot = data1_reg[SSLOT_LSB +: SLOT_W];

    always_comb begin
        is_decode = (cmd1_reg == CMD_DECODE);
        en2       = !v2_reg || m_tready;
        fire1     = v1_reg && (!is_decode || en2);
        dec_fire  = fire1 && is_decode;
        s_tready  = !v1_reg || fire1;
        s_accept  = s_tvalid && s_tready;
        v1_next   = s_accept || (v1_reg && !fire1);
        v2_next   = dec_fire || (v2_reg && !m_tready);
        len_wr    = fire1 && (cmd1_reg == CMD_LOAD_LENGTH) &&
                    (length_slot <= LSLOT_W'(MAX_LEN));
        sym_wr    = fire1 && (cmd1_reg == CMD_LOAD_SYMBOL) &&
                    ((SLOT_W+1)'(symbol_slot) < (SLOT_W+1)'(SYMBOLS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd1_reg  <= s_tuser;
            data1_reg <= s_tdata;
        end
        if (dec_fire) begin
            len2_reg <= search.found_len;
            bad2_reg <= search.bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (len_wr) begin
            fc_table_reg[length_slot] <= data1_reg[FCODE_LSB +: CODE_W];
            fi_table_reg[length_slot] <= data1_reg[FINDEX_LSB +: INDEX_W];
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcl_reg   <= MCL_RESET;
            count_reg <= COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_CODE_LENGTH: mcl_reg   <= cfg_data[LSLOT_W-1:0];
                REG_SYMBOL_COUNT:    count_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    chd_length_search u_search (
        .bit_window      (data1_reg[WINDOW_LSB +: WINDOW_W]),
        .max_code_length (mcl_reg),
        .symbol_count    (count_reg),
        .fc_table        (fc_table_reg),
        .fi_table        (fi_table_reg),
        .result          (search)
    );

    chd_symbol_store u_store (
        .aclk    (aclk),
        .wr_en   (sym_wr),
        .wr_addr (symbol_slot[ADDR_W-1:0]),
        .wr_data (data1_reg[SVALUE_LSB +: SYMBOL_BITS]),
        .rd_en   (dec_fire),
        .rd_addr (search.addr),
        .rd_data (rd_symbol)
    );

    assign m_tvalid = v2_reg;
    assign m_tuser  = bad2_reg;
    assign m_tdata  = {(M_DATA_W-M_DATA_RAW)'(0),
                       rd_symbol & {SYMBOL_BITS{~bad2_reg}},
                       len2_reg};

endmodule

/* hw/rtl/chd_checker.sv */
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module chd_checker
    import chd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an out of range index gives a zero symbol
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OUT_LEN_W +: OUT_SYM_W] == '0)
        else $error("bad code with nonzero symbol");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_LEN_W-1:0] <= OUT_LEN_W'(MAX_LEN))
        else $error("code length beyond longest length");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:M_DATA_RAW] == '0)
        else $error("tdata padding not zero");

endmodule

bind canonical_huffman_decoder chd_checker u_chd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* dv/canonical_huffman_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_test
// Self-checking bench for the canonical huffman decoder. It fills the length
// table and symbol store, drives corner windows under extreme register
// settings, decodes streams built from random canonical codes, and finishes
// with random command traffic. Every accepted item passes through an
// in-bench decoder model, and each result transfer is checked against the
// oldest predicted result. Both sides idle and stall at random, apart from the steady-stream phase.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder_test;
    import chd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [CMD_W-1:0]   command;
        logic [LSLOT_W-1:0] length_slot;
        code_t              fcode_val;
        index_t             findex_val;
        logic [SLOT_W-1:0]  symbol_slot;
        symbol_t            symbol_value;
        logic [WINDOW_W-1:0] bit_window;
    } huff_item_t;

    typedef struct {
        logic [OUT_LEN_W-1:0] len_out;
        symbol_t              symbol;
        logic                 bad_code;
    } decode_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // decoder state as the bench sees it
    code_t             fc_tab  [0:MAX_LEN];
    index_t            fi_tab  [0:MAX_LEN];
    symbol_t           sym_mem [0:SYMBOLS-1];
    logic [LSLOT_W-1:0] window_bits   = MCL_RESET;
    logic [COUNT_W-1:0] count_model   = COUNT_RESET;

    // current canonical code: length and code of each symbol rank
    int unsigned       canon_len  [0:SYMBOLS-1];
    int unsigned       canon_code [0:SYMBOLS-1];

    decode_result_t    expected_codes [$];
    int unsigned       error_count  = 0;
    int unsigned       results_seen = 0;
    bit                gaps_on      = 1'b1;

    canonical_huffman_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic decode_result_t decode_window(input logic [WINDOW_W-1:0] bits);
        decode_result_t res;
        int unsigned    width;
        int unsigned    len;
        logic [63:0]    win;
        logic [63:0]    code;
        logic [63:0]    idx;
        width = (window_bits > MAX_LEN) ? MAX_LEN : window_bits;
        win   = 64'(bits) & ((64'd1 << width) - 64'd1);
        len   = 0;
        // longest length whose left-aligned first code does not exceed the window
        for (int unsigned m = 1; m <= width; m++) begin
            if ((64'(fc_tab[m]) << (width - m)) <= win) len = m;
        end
        code = (len == 0) ? 64'd0 : (win >> (width - len));
        idx  = 64'(fi_tab[len]) + code - 64'(fc_tab[len]);
        res.len_out  = OUT_LEN_W'(len);
        res.bad_code = (idx >= 64'(count_model)) || (idx >= 64'(SYMBOLS));
        res.symbol   = res.bad_code ? '0 : sym_mem[idx[ADDR_W-1:0]];
        return res;
    endfunction

    function automatic void apply_item(input huff_item_t it);
        case (it.command)
            CMD_LOAD_LENGTH: begin
                if (it.length_slot <= MAX_LEN) begin
                    fc_tab[it.length_slot] = it.fcode_val;
                    fi_tab[it.length_slot] = it.findex_val;
                end
            end
            CMD_LOAD_SYMBOL: begin
                sym_mem[it.symbol_slot] = it.symbol_value;
            end
            CMD_DECODE: begin
                expected_codes.insert(expected_codes.size(), decode_window(it.bit_window));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic huff_item_t random_item();
        huff_item_t it;
        it.command      = CMD_W'($urandom_range(0, 3));
        it.length_slot  = LSLOT_W'($urandom);
        it.fcode_val    = code_t'($urandom);
        it.findex_val   = index_t'($urandom);
        it.symbol_slot  = SLOT_W'($urandom);
        it.symbol_value = symbol_t'($urandom);
        it.bit_window   = WINDOW_W'($urandom);
        return it;
    endfunction

    // one input transfer; valid stays high for a following item
    task automatic send_item(input huff_item_t it);
        if (gaps_on && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= S_DATA_W'({it.bit_window, it.symbol_value, it.symbol_slot,
                               it.findex_val, it.fcode_val, it.length_slot});
        do @(posedge aclk); while (!s_tready);
        apply_item(it);
    endtask

    task automatic send_load_length(input int unsigned slot, input int unsigned fcode,
                                    input int unsigned findex);
        huff_item_t it;
        it             = random_item();
        it.command     = CMD_LOAD_LENGTH;
        it.length_slot = LSLOT_W'(slot);
        it.fcode_val   = code_t'(fcode);
        it.findex_val  = index_t'(findex);
        send_item(it);
    endtask

    task automatic send_load_symbol(input int unsigned slot, input int unsigned value);
        huff_item_t it;
        it              = random_item();
        it.command      = CMD_LOAD_SYMBOL;
        it.symbol_slot  = SLOT_W'(slot);
        it.symbol_value = symbol_t'(value);
        send_item(it);
    endtask

    task automatic send_decode(input int unsigned bits);
        huff_item_t it;
        it            = random_item();
        it.command    = CMD_DECODE;
        it.bit_window = WINDOW_W'(bits);
        send_item(it);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        // loads in flight have no result to wait for
        repeat (4) @(posedge aclk);
    endtask

    // only called with the decoder idle
    task automatic write_regs(input int unsigned mcl, input int unsigned count);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_CODE_LENGTH;
        cfg_data  <= CFG_DATA_W'(mcl & 32'h1f);
        do @(posedge aclk); while (!cfg_ready);
        window_bits = LSLOT_W'(mcl);
        cfg_index <= REG_SYMBOL_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        do @(posedge aclk); while (!cfg_ready);
        count_model = COUNT_W'(count);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_result();
        decode_result_t want;
        logic [OUT_LEN_W-1:0] got_len;
        symbol_t              got_sym;
        got_len = m_tdata[OUT_LEN_W-1:0];
        got_sym = m_tdata[OUT_LEN_W +: OUT_SYM_W];
        results_seen++;
        if (expected_codes.size() == 0) begin
            note_error($sformatf("result %0d unexpected: len %0d sym %h bad %b",
                                 results_seen, got_len, got_sym, m_tuser));
        end else begin
            want = expected_codes.pop_front();
            if (got_len !== want.len_out || got_sym !== want.symbol ||
                m_tuser !== want.bad_code) begin
                note_error($sformatf(
                    "result %0d: expected len %0d sym %h bad %b, got len %0d sym %h bad %b",
                    results_seen, want.len_out, want.symbol, want.bad_code,
                    got_len, got_sym, m_tuser));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= 10);
    end

    // every table and store entry gets a value before anything decodes
    task automatic test_fill_tables();
        for (int unsigned s = 0; s <= MAX_LEN; s++) begin
            send_load_length(s, $urandom, $urandom);
        end
        for (int unsigned s = 0; s < SYMBOLS; s++) begin
            send_load_symbol(s, $urandom);
        end
    endtask

    task automatic test_corner_items();
        huff_item_t it;
        send_load_length(17, $urandom, $urandom);       // slot past the table
        send_load_length(31, 16'hffff, 9'h1ff);
        it         = random_item();
        it.command = CMD_UNUSED;
        send_item(it);
        send_load_symbol(0, 16'hffff);
        send_load_symbol(255, 16'h0000);
        send_load_length(16, 16'hffff, 256);            // all-ones window hits index 256
        send_decode(16'h0000);
        send_decode(16'hffff);
        send_decode(16'hfffe);
        send_decode(16'h8000);
    endtask

    task automatic test_window_settings();
        // zero- and one-bit windows: zero misses every length, index wraps below zero
        send_load_length(0, 5, 0);
        send_load_length(1, 1, 255);
        wait_drain();
        write_regs(0, 256);
        send_decode(16'hffff);
        send_decode($urandom);
        wait_drain();
        write_regs(1, 256);
        send_decode(16'h0000);
        send_decode(16'hffff);
        send_decode(16'hfffe);
        wait_drain();
        write_regs(31, 511);
        send_decode(16'hffff);
        send_decode($urandom);
        wait_drain();
        write_regs(16, 1);
        send_decode(16'h0000);
        send_decode($urandom);
    endtask

    task automatic load_canonical_code(input int unsigned max_len, input int unsigned budget,
                                       input int unsigned base, output int unsigned total);
        int unsigned code_next;
        int unsigned room;
        int unsigned n;
        code_next = 0;
        total     = 0;
        for (int unsigned m = 1; m <= MAX_LEN; m++) begin
            room = (32'd1 << m) - code_next;
            n    = 0;
            // leave one code free per length so first codes never overflow
            if (m == max_len && total == 0) begin
                n = 1;
            end else if (m <= max_len && total < budget) begin
                n = $urandom_range(0, (room - 1 < budget - total) ? room - 1 : budget - total);
            end
            send_load_length(m, code_next, base + total);
            for (int unsigned k = 0; k < n; k++) begin
                canon_len[total + k]  = m;
                canon_code[total + k] = code_next + k;
            end
            total     = total + n;
            code_next = (code_next + n) << 1;
        end
        for (int unsigned j = 0; j < total; j++) begin
            send_load_symbol(base + j, $urandom);
        end
    endtask

    task automatic run_canonical_phase(input int unsigned max_len, input int unsigned budget,
                                       input int unsigned decodes);
        int unsigned base;
        int unsigned total;
        int unsigned j;
        int unsigned shift;
        int unsigned pick;
        int unsigned win;
        int unsigned keep;
        huff_item_t  it;
        wait_drain();
        base = $urandom_range(0, SYMBOLS - budget);
        load_canonical_code(max_len, budget, base, total);
        wait_drain();
        if ($urandom_range(0, 3) == 0) write_regs(max_len, $urandom_range(1, base + total));
        else write_regs(max_len, base + total);
        keep = (32'd1 << max_len) - 1;
        for (int unsigned i = 0; i < decodes; i++) begin
            pick = $urandom_range(0, 99);
            it   = random_item();
            if (pick < 85) begin
                j     = $urandom_range(0, total - 1);
                shift = max_len - canon_len[j];
                win   = canon_code[j] << shift;
                // mostly a code followed by more stream, sometimes the stream ends
                if ($urandom_range(0, 9) != 0) win = win | ($urandom & ((32'd1 << shift) - 1));
                it.command    = CMD_DECODE;
                it.bit_window = WINDOW_W'(($urandom & ~keep) | (win & keep));
            end else if (pick < 89) begin
                it.command = CMD_UNUSED;
            end else if (pick < 92) begin
                it.command     = CMD_LOAD_LENGTH;
                it.length_slot = LSLOT_W'($urandom_range(MAX_LEN + 1, 31));
            end else if (pick < 96) begin
                it.command = CMD_DECODE;
            end else begin
                it.command = CMD_LOAD_SYMBOL;
            end
            send_item(it);
        end
    endtask

    task automatic test_canonical_streams();
        run_canonical_phase(16, 64, 40);
        run_canonical_phase(1, 1, 20);
        run_canonical_phase(8, 32, 40);
        run_canonical_phase($urandom_range(2, 15), $urandom_range(8, 32), 40);
    endtask

    task automatic test_steady_stream();
        wait_drain();
        gaps_on = 1'b0;
        run_canonical_phase(10, 32, 60);
        wait_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_mix();
        wait_drain();
        write_regs($urandom_range(0, 31), $urandom_range(1, 511));
        for (int unsigned i = 0; i < 100; i++) begin
            if (i == 50) wait_drain();
            send_item(random_item());
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill_tables();
        test_corner_items();
        test_window_settings();
        test_canonical_streams();
        test_steady_stream();
        test_random_mix();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_codes.size() == 0) begin
            $display("canonical_huffman_decoder_test: done, clean");
        end else begin
            $display("canonical_huffman_decoder_test: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("canonical_huffman_decoder_test: done, errors");
        $finish;
    end

endmodule
